FILE: src/fca_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the allocation table chain allocator
// no dependencies

package fca_pkg;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_APPEND = 2'd1,
		OP_FREE   = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_FREE = 2'd1,
		STAT_RANGE   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_RD_REQ,
		S_RD_GET,
		S_AP_REQ,
		S_AP_GET,
		S_SCAN,
		S_WR_A,
		S_WR_B,
		S_FR_REQ,
		S_FR_CHK,
		S_DONE
	} fsm_t;

	typedef struct packed {
		status_t            status;
		logic [7:0]         first_block;
		logic [7:0]         second_block;
		logic signed [8:0]  next_link;
		logic               entry_used;
		logic [8:0]         freed_count;
	} result_t;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 40;
	localparam logic signed [8:0] LINK_END = -9'sd1;

endpackage

FILE: src/fca_table.sv
`timescale 1ns / 1ps
// table memory: one write port, one read port with registered read data
// no dependencies

module fca_table #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/fca_ctrl.sv
`timescale 1ns / 1ps
// sequencer for the allocator: clearing pass, free-entry scan, chain walk
// depends on fca_pkg; drives the table memory in fca_table

module fca_ctrl #(
	parameter int TABLE_ENTRIES = 256,
	localparam int IW = $clog2(TABLE_ENTRIES),
	localparam int EW = IW + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fca_pkg::op_t      in_op,
	input  logic [7:0]        in_idx,
	output logic              res_valid,
	input  logic              res_ready,
	output fca_pkg::result_t  res,
	output logic              mem_we,
	output logic [IW-1:0]     mem_waddr,
	output logic [EW-1:0]     mem_wdata,
	output logic              mem_re,
	output logic [IW-1:0]     mem_raddr,
	input  logic [EW-1:0]     mem_rdata
);

	import fca_pkg::*;

	localparam logic [IW:0]   NUM_W     = (IW+1)'(TABLE_ENTRIES);
	localparam logic [IW-1:0] LAST_ADDR = IW'(TABLE_ENTRIES - 1);
	// entry layout: used flag, end marker, link
	localparam logic [EW-1:0] EMPTY_ENTRY = {1'b0, 1'b1, {IW{1'b0}}};

	fsm_t          state_q, state_d;
	op_t           op_q;
	logic [7:0]    idx_q;
	result_t       res_q;
	logic [IW-1:0] clr_q;
	logic [IW:0]   scan_addr_q;
	logic          scan_pend_q;
	logic [IW-1:0] scan_paddr_q;
	logic [IW-1:0] addr_a_q;
	logic [IW-1:0] addr_b_q;
	logic          have_a_q;
	logic          tail_used_q;
	logic [IW-1:0] cur_q;
	logic [IW:0]   steps_q;
	logic [IW:0]   freed_q;

	logic          in_range;
	logic [IW-1:0] idx_addr;
	logic          rd_used;
	logic          rd_term;
	logic [IW-1:0] rd_link;
	logic          scan_issue;
	logic          scan_hit;
	logic          scan_fail;
	logic          scan_last;
	logic          walk_limit;
	logic [IW:0]   freed_next;

	assign in_range   = 32'(idx_q) < 32'(TABLE_ENTRIES);
	assign idx_addr   = IW'(idx_q);
	assign rd_used    = mem_rdata[IW+1];
	assign rd_term    = mem_rdata[IW];
	assign rd_link    = mem_rdata[IW-1:0];
	assign scan_issue = scan_addr_q < NUM_W;
	assign scan_hit   = scan_pend_q && !rd_used;
	assign scan_fail  = !scan_pend_q && !scan_issue;
	// a hit ends the scan unless it is the first of an allocate pair
	assign scan_last  = scan_hit && ((op_q != OP_ALLOC) || have_a_q);
	assign walk_limit = steps_q == NUM_W;
	assign freed_next = freed_q + (IW+1)'(rd_used);
	assign res        = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:    if (clr_q == LAST_ADDR) state_d = S_IDLE;
			S_IDLE:     if (in_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				if (op_q == OP_ALLOC) begin
					state_d = S_SCAN;
				end else if (!in_range) begin
					state_d = S_DONE;
				end else begin
					unique case (op_q)
						OP_APPEND: state_d = S_AP_REQ;
						OP_FREE:   state_d = S_FR_REQ;
						default:   state_d = S_RD_REQ;
					endcase
				end
			end
			S_RD_REQ:   state_d = S_RD_GET;
			S_RD_GET:   state_d = S_DONE;
			S_AP_REQ:   state_d = S_AP_GET;
			S_AP_GET:   state_d = S_SCAN;
			S_SCAN: begin
				if (scan_last) state_d = S_WR_A;
				else if (scan_fail) state_d = S_DONE;
			end
			S_WR_A:     state_d = S_WR_B;
			S_WR_B:     state_d = S_DONE;
			S_FR_REQ:   state_d = walk_limit ? S_DONE : S_FR_CHK;
			S_FR_CHK:   state_d = rd_term ? S_DONE : S_FR_REQ;
			S_DONE:     if (res_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = EMPTY_ENTRY;
		mem_re    = 1'b0;
		mem_raddr = idx_addr;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_IDLE:   in_ready = 1'b1;
			S_RD_REQ, S_AP_REQ: mem_re = 1'b1;
			S_SCAN: begin
				mem_re    = scan_issue;
				mem_raddr = scan_addr_q[IW-1:0];
			end
			S_WR_A: begin
				mem_we = 1'b1;
				if (op_q == OP_ALLOC) begin
					mem_waddr = addr_a_q;
					mem_wdata = {1'b1, 1'b0, addr_b_q};
				end else begin
					mem_waddr = idx_addr;
					mem_wdata = {tail_used_q, 1'b0, addr_a_q};
				end
			end
			S_WR_B: begin
				// written after the tail so a tail that is itself the new entry ends up used
				mem_we    = 1'b1;
				mem_waddr = (op_q == OP_ALLOC) ? addr_b_q : addr_a_q;
				mem_wdata = {1'b1, 1'b1, {IW{1'b0}}};
			end
			S_FR_REQ: begin
				mem_re    = !walk_limit;
				mem_raddr = cur_q;
			end
			S_FR_CHK: mem_we = 1'b1;
			S_DONE:   res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			scan_pend_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_pend_q <= (state_q == S_SCAN) && scan_issue && !scan_last;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q        <= in_op;
					idx_q       <= in_idx;
					res_q       <= '0;
					have_a_q    <= 1'b0;
					scan_addr_q <= '0;
					steps_q     <= '0;
					freed_q     <= '0;
				end
			end
			S_DISPATCH: begin
				cur_q <= idx_addr;
				if (op_q != OP_ALLOC && !in_range) begin
					res_q.status <= STAT_RANGE;
					if (op_q == OP_READ) begin
						res_q.next_link <= LINK_END;
					end
				end
			end
			S_RD_GET: begin
				res_q.next_link  <= rd_term ? LINK_END : 9'(rd_link);
				res_q.entry_used <= rd_used;
			end
			S_AP_GET: tail_used_q <= rd_used;
			S_SCAN: begin
				if (scan_issue) begin
					scan_addr_q <= scan_addr_q + 1'b1;
				end
				scan_paddr_q <= scan_addr_q[IW-1:0];
				if (scan_hit) begin
					if (op_q == OP_ALLOC && have_a_q) begin
						addr_b_q <= scan_paddr_q;
					end else begin
						addr_a_q <= scan_paddr_q;
						have_a_q <= 1'b1;
					end
				end else if (scan_fail) begin
					res_q.status <= STAT_NO_FREE;
				end
			end
			S_WR_B: begin
				res_q.first_block <= 8'(addr_a_q);
				if (op_q == OP_ALLOC) begin
					res_q.second_block <= 8'(addr_b_q);
				end
			end
			S_FR_REQ: begin
				if (walk_limit) begin
					res_q.status <= STAT_RANGE;
				end
			end
			S_FR_CHK: begin
				freed_q           <= freed_next;
				res_q.freed_count <= 9'(freed_next);
				steps_q           <= steps_q + 1'b1;
				cur_q             <= rd_link;
			end
			default: ;
		endcase
	end

endmodule

FILE: src/fat_chain_block_allocator.sv
`timescale 1ns / 1ps
// Allocation table chain allocator: a table of TABLE_ENTRIES entries, each a used flag
// and a next link (or end marker), serving allocate pair, append, free chain and read.
//
// Requests arrive on the s_ stream (op, block_index), one result per request leaves on
// the m_ stream. One request is worked on at a time; s_tready is high only while the
// sequencer is idle. All table traffic goes through one single-port-read memory whose
// read data is registered, so each look-up is issued before its result is used:
//   read link        reads the entry and returns its link and used flag
//   allocate pair    scans from entry 0 for two free entries, then writes both
//   append           reads the tail, scans for the lowest free entry, writes tail and entry
//   free chain       walks the chain from the head, per visited entry a read, then a clear
// The free-entry scan reads one entry per cycle; the chain walk reads, then clears each link.
// After reset the table is cleared one entry a cycle, with s_tready low throughout.
// A finished result sits in an output register; while the receiver stalls the next
// request may still be taken and worked on, and it waits in the sequencer until the
// output register frees up.
// depends on fca_pkg, fca_table, fca_ctrl

module fat_chain_block_allocator #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fca_pkg::S_TDATA_W-1:0]  s_tdata,  // op[1:0], block_index[9:2]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status[1:0], first_block[9:2], second_block[17:10], next_link[26:18],
	// entry_used[27], freed_count[36:28]
	output logic [fca_pkg::M_TDATA_W-1:0]  m_tdata
);

	import fca_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int EW = IW + 2;

	logic          res_valid;
	logic          res_ready;
	result_t       res;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	logic [EW-1:0] mem_rdata;

	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	fca_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (op_t'(s_tdata[1:0])),
		.in_idx    (s_tdata[9:2]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	fca_table #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (IW),
		.DW    (EW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register takes a new result whenever the previous one has been transferred
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= {3'b000, res.freed_count, res.entry_used, res.next_link,
				res.second_block, res.first_block, res.status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: src/fca_checker.sv
`timescale 1ns / 1ps
// port-level checks for the allocator, bound to the top level
// depends on fca_pkg for the status codes and the fat_chain_block_allocator port layout

module fca_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [fca_pkg::M_TDATA_W-1:0]  m_tdata
);

	import fca_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// only one request in work at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == STAT_OK) || (m_tdata[1:0] == STAT_NO_FREE) ||
			(m_tdata[1:0] == STAT_RANGE))
		else $error("undefined status code");

	// a failed request allocates nothing
	a_fail_no_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != STAT_OK |-> m_tdata[17:2] == 16'd0)
		else $error("blocks reported on a failed request");

	// read link and free chain fields stay clear on a no-space result
	a_no_free_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == STAT_NO_FREE |-> m_tdata[39:18] == 22'd0)
		else $error("stray fields on a no-space result");

endmodule

bind fat_chain_block_allocator fca_checker u_fca_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// self-checking bench for fat_chain_block_allocator: a mirror of the table predicts every
// result, then directed, full-table and random request streams are played against it
// depends on fca_pkg and the block itself

module tb;
	import fca_pkg::*;

	localparam int ENTRIES        = 256;
	localparam int RANDOM_REQS    = 1070;
	localparam int WATCHDOG_LIMIT = 4000;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// mirror of the allocation table, -1 is the end marker
	bit      mirror_used [ENTRIES];
	int      mirror_link [ENTRIES];
	result_t pending_results [$];
	result_t last_prediction;
	int      fail_count   = 0;
	int      stall_cycles = 0;
	bit      src_steady   = 1'b0;
	bit      snk_steady   = 1'b0;

	fat_chain_block_allocator #(
		.TABLE_ENTRIES(ENTRIES)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		m_tready <= snk_steady || ($urandom_range(0, 99) >= 7);

	function automatic int lowest_free(input int from);
		for (int i = from; i < ENTRIES; i++)
			if (!mirror_used[i])
				return i;
		return -1;
	endfunction

	function automatic result_t table_step(input op_t op, input int idx);
		result_t r;
		int a, b, cur, nxt, steps, freed;
		r = '0;
		case (op)
		OP_ALLOC: begin
			a = lowest_free(0);
			b = (a < 0) ? -1 : lowest_free(a + 1);
			if (b < 0) begin
				r.status = STAT_NO_FREE;
			end else begin
				mirror_used[a] = 1'b1;
				mirror_link[a] = b;
				mirror_used[b] = 1'b1;
				mirror_link[b] = -1;
				r.first_block  = 8'(a);
				r.second_block = 8'(b);
			end
		end
		OP_APPEND: begin
			if (idx >= ENTRIES) begin
				r.status = STAT_RANGE;
			end else begin
				a = lowest_free(0);
				if (a < 0) begin
					r.status = STAT_NO_FREE;
				end else begin
					// tail link goes first so a tail that is itself the pick ends up terminated
					mirror_link[idx] = a;
					mirror_used[a]   = 1'b1;
					mirror_link[a]   = -1;
					r.first_block    = 8'(a);
				end
			end
		end
		OP_FREE: begin
			if (idx >= ENTRIES) begin
				r.status = STAT_RANGE;
			end else begin
				cur   = idx;
				steps = 0;
				freed = 0;
				while (cur >= 0 && cur < ENTRIES) begin
					// step guard against a chain that loops through the whole table
					if (steps >= ENTRIES) begin
						r.status = STAT_RANGE;
						break;
					end
					if (mirror_used[cur])
						freed++;
					mirror_used[cur] = 1'b0;
					nxt = mirror_link[cur];
					mirror_link[cur] = -1;
					cur = nxt;
					steps++;
				end
				r.freed_count = 9'(freed);
			end
		end
		default: begin
			if (idx >= ENTRIES) begin
				r.status    = STAT_RANGE;
				r.next_link = LINK_END;
			end else begin
				r.next_link  = (mirror_link[idx] < 0) ? LINK_END : 9'(mirror_link[idx]);
				r.entry_used = mirror_used[idx];
			end
		end
		endcase
		return r;
	endfunction

	task automatic send_req(input op_t op, input logic [7:0] idx);
		if (!src_steady && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - 10){1'b0}}, idx, op};
		do @(posedge clk); while (!s_tready);
		last_prediction = table_step(op, idx);
		pending_results.push_back(last_prediction);
	endtask

	task automatic check_field(input string name, input logic signed [10:0] want,
		input logic signed [10:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing outstanding, m_tdata %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, m_tdata[1:0]);
				check_field("first_block", want.first_block, m_tdata[9:2]);
				check_field("second_block", want.second_block, m_tdata[17:10]);
				check_field("next_link", want.next_link, $signed(m_tdata[26:18]));
				check_field("entry_used", want.entry_used, m_tdata[27]);
				check_field("freed_count", want.freed_count, m_tdata[36:28]);
			end
		end
	end

	task automatic test_directed();
		send_req(OP_READ, 8'd0);      // untouched entry
		send_req(OP_READ, 8'd255);
		send_req(OP_FREE, 8'd0);      // nothing to release
		send_req(OP_APPEND, 8'd0);    // tail is the lowest free entry itself
		send_req(OP_READ, 8'd0);
		send_req(OP_ALLOC, 8'd0);
		send_req(OP_READ, 8'd1);
		send_req(OP_APPEND, 8'd2);
		send_req(OP_APPEND, 8'd1);    // tail in mid chain, its link is overwritten
		send_req(OP_READ, 8'd1);
		send_req(OP_READ, 8'd2);
		send_req(OP_APPEND, 8'd200);  // free tail that is not the pick
		send_req(OP_READ, 8'd200);
		send_req(OP_FREE, 8'd200);    // unused head, used successor
		send_req(OP_FREE, 8'd1);
		send_req(OP_FREE, 8'd2);      // orphaned tail of the old chain
		send_req(OP_ALLOC, 8'hff);    // index is ignored here
		send_req(OP_READ, 8'haa);
		send_req(OP_READ, 8'h55);
		send_req(OP_FREE, 8'd0);
	endtask

	task automatic test_full_table();
		src_steady = 1'b1;
		snk_steady = 1'b1;
		for (int i = 0; i < ENTRIES; i++)
			if (mirror_used[i])
				send_req(OP_FREE, 8'(i));
		// one chain through every entry, in index order
		send_req(OP_ALLOC, 8'd0);
		for (int i = 1; i < ENTRIES - 1; i++)
			send_req(OP_APPEND, 8'(i));
		send_req(OP_ALLOC, 8'd0);
		send_req(OP_APPEND, 8'd255);
		send_req(OP_FREE, 8'd255);
		send_req(OP_ALLOC, 8'd0);     // a single free entry is not a pair
		send_req(OP_APPEND, 8'd254);
		send_req(OP_READ, 8'd255);
		send_req(OP_READ, 8'd254);
		send_req(OP_FREE, 8'd0);      // releases the whole table
		src_steady = 1'b0;
		snk_steady = 1'b0;
	endtask

	task automatic test_random();
		int   heads [$];
		int   tail_hint;
		int   pick;
		int   used_n;
		int   slot;
		op_t  op;
		logic [7:0] idx;
		tail_hint = -1;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			src_steady = (n >= 500 && n < 700);
			snk_steady = src_steady;
			used_n = 0;
			foreach (mirror_used[i])
				used_n += mirror_used[i];
			pick = $urandom_range(0, 99);
			if (pick < 30)
				op = OP_ALLOC;
			else if (pick < 55)
				op = OP_APPEND;
			else if (pick < 75)
				op = OP_FREE;
			else
				op = OP_READ;
			// crowded table: drain more often so occupancy keeps moving
			if (used_n > 192 && (op == OP_ALLOC || op == OP_APPEND) && $urandom_range(0, 1))
				op = OP_FREE;
			idx = 8'($urandom);
			case (op)
			OP_APPEND: begin
				if (tail_hint >= 0 && $urandom_range(0, 9) < 7)
					idx = 8'(tail_hint);
			end
			OP_FREE: begin
				if (heads.size() != 0 && $urandom_range(0, 9) < 7) begin
					slot = $urandom_range(0, heads.size() - 1);
					idx  = 8'(heads[slot]);
					heads.delete(slot);
				end
			end
			OP_READ: begin
				if (tail_hint >= 0 && $urandom_range(0, 3) == 0)
					idx = 8'(tail_hint);
			end
			default: ;
			endcase
			send_req(op, idx);
			if (last_prediction.status == STAT_OK) begin
				if (op == OP_ALLOC) begin
					heads.push_back(last_prediction.first_block);
					tail_hint = last_prediction.second_block;
				end else if (op == OP_APPEND) begin
					tail_hint = last_prediction.first_block;
				end
			end
		end
		s_tvalid <= 1'b0;
		src_steady = 1'b0;
		snk_steady = 1'b0;
	endtask

	// ends the run when neither side has moved a transfer for too long
	initial begin
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			mirror_used[i] = 1'b0;
			mirror_link[i] = -1;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_table();
		test_random();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
